FILE: rtl/spt_pkg.sv
// Shared constants, record layout and controller/datapath signal groups.
package spt_pkg;

    // Table size and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths
    localparam int KIND_W   = 2;
    localparam int TAG_W    = 16;
    localparam int AGE_W    = 8;
    localparam int SEV_W    = 3;
    localparam int STATUS_W = 2;
    localparam int KEY_W    = AGE_W + IDX_W;

    // Stream widths, padded to whole bytes
    localparam int IN_BITS    = TAG_W + AGE_W + SEV_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int IN_PAD_W   = IN_DATA_W - IN_BITS;
    localparam int OUT_BITS   = STATUS_W + TAG_W + AGE_W + SEV_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

    localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(CAPACITY);

    // Command kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LIST   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_SEV = 2'd3;

    // Accepted severity range
    localparam logic [SEV_W-1:0] SEV_MIN = 3'd1;
    localparam logic [SEV_W-1:0] SEV_MAX = 3'd4;

    // Sweep modes
    localparam logic [1:0] MODE_MAX_SEV = 2'd0;
    localparam logic [1:0] MODE_SHIFT   = 2'd1;
    localparam logic [1:0] MODE_MIN_KEY = 2'd2;

    typedef struct packed {
        logic [SEV_W-1:0] sev;
        logic [AGE_W-1:0] age;
        logic [TAG_W-1:0] tag;
    } rec_t;

    typedef struct packed {
        logic                load_in;
        logic                ins_write;
        logic                sweep_start;
        logic [1:0]          sweep_mode;
        logic                fill_dec;
        logic                list_reset;
        logic                list_next;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
        logic                res_rec;
        logic                res_last;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              sev_bad;
        logic              full;
        logic              empty;
        logic              sweep_done;
        logic              list_last;
        logic [CNT_W-1:0]  fill;
    } sts_t;

endpackage

FILE: rtl/spt_ctrl.sv
// Sequencing controller for the severity priority table.
module spt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  spt_pkg::sts_t sts,
    output spt_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_SEL    = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_LSCAN  = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;
    localparam logic [2:0] S_LEMIT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_EMIT) || (state_reg == S_LEMIT);

    // Decode state and status into datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                case (sts.kind)
                    spt_pkg::KIND_INSERT:
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_last = 1'b1;
                        if (sts.sev_bad)
                            cmd.res_status = spt_pkg::ST_BAD_SEV;
                        else if (sts.full)
                            cmd.res_status = spt_pkg::ST_FULL;
                        else
                        begin
                            cmd.res_status = spt_pkg::ST_OK;
                            cmd.ins_write  = 1'b1;
                        end
                        state_next = S_EMIT;
                    end
                    spt_pkg::KIND_REMOVE:
                    begin
                        if (sts.empty)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = spt_pkg::ST_EMPTY;
                            cmd.res_last   = 1'b1;
                            state_next     = S_EMIT;
                        end
                        else
                        begin
                            cmd.sweep_start = 1'b1;
                            cmd.sweep_mode  = spt_pkg::MODE_MAX_SEV;
                            state_next      = S_SEL;
                        end
                    end
                    spt_pkg::KIND_LIST:
                    begin
                        if (sts.empty)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = spt_pkg::ST_EMPTY;
                            cmd.res_last   = 1'b1;
                            state_next     = S_EMIT;
                        end
                        else
                        begin
                            cmd.list_reset  = 1'b1;
                            cmd.sweep_start = 1'b1;
                            cmd.sweep_mode  = spt_pkg::MODE_MIN_KEY;
                            state_next      = S_LSCAN;
                        end
                    end
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_SEL:
            begin
                // Latch the pick as the result, then close the gap behind it
                if (sts.sweep_done)
                begin
                    cmd.res_load    = 1'b1;
                    cmd.res_status  = spt_pkg::ST_OK;
                    cmd.res_rec     = 1'b1;
                    cmd.res_last    = 1'b1;
                    cmd.sweep_start = 1'b1;
                    cmd.sweep_mode  = spt_pkg::MODE_SHIFT;
                    state_next      = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (sts.sweep_done)
                begin
                    cmd.fill_dec = 1'b1;
                    state_next   = S_EMIT;
                end
            end
            S_LSCAN:
            begin
                if (sts.sweep_done)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = spt_pkg::ST_OK;
                    cmd.res_rec    = 1'b1;
                    cmd.res_last   = sts.list_last;
                    state_next     = S_LEMIT;
                end
            end
            S_EMIT:
            begin
                if (m_tready)
                    state_next = S_IDLE;
            end
            S_LEMIT:
            begin
                // Advance to the next record in age order once the beat is taken
                if (m_tready)
                begin
                    if (sts.list_last)
                        state_next = S_IDLE;
                    else
                    begin
                        cmd.list_next   = 1'b1;
                        cmd.sweep_start = 1'b1;
                        cmd.sweep_mode  = spt_pkg::MODE_MIN_KEY;
                        state_next      = S_LSCAN;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: rtl/spt_datapath.sv
// Record store, sweep engine, selection logic and result register.
module spt_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [spt_pkg::IN_DATA_W-1:0]        s_tdata,
    input  logic [spt_pkg::KIND_W-1:0]           s_tuser,
    input  spt_pkg::cmd_t                        cmd,
    output spt_pkg::sts_t                        sts,
    output logic [spt_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                 m_tlast
);

    // Record store: one write port, one registered read port
    spt_pkg::rec_t mem [spt_pkg::CAPACITY];
    spt_pkg::rec_t rd_data_reg;
    logic                         wr_en;
    logic [spt_pkg::IDX_W-1:0]    wr_addr;
    spt_pkg::rec_t                wr_data;

    // Latched input beat
    logic [spt_pkg::KIND_W-1:0]   kind_reg;
    spt_pkg::rec_t                in_rec_reg;

    logic [spt_pkg::CNT_W-1:0]    fill_reg;

    // Sweep engine
    logic                         active_reg;
    logic                         pvld_reg;
    logic [spt_pkg::CNT_W-1:0]    idx_reg;
    logic [spt_pkg::CNT_W-1:0]    idx_start;
    logic [spt_pkg::IDX_W-1:0]    pidx_reg;
    logic [1:0]                   mode_reg;

    // Selection state
    logic [spt_pkg::SEV_W-1:0]    best_sev_reg;
    logic [spt_pkg::IDX_W-1:0]    best_idx_reg;
    spt_pkg::rec_t                best_rec_reg;
    logic [spt_pkg::KEY_W-1:0]    best_key_reg;
    logic                         found_reg;
    logic [spt_pkg::KEY_W-1:0]    prev_key_reg;
    logic                         have_prev_reg;
    logic [spt_pkg::CNT_W-1:0]    list_cnt_reg;
    logic [spt_pkg::KEY_W-1:0]    key_cur;
    logic                         take_sev;
    logic                         take_key;

    // Result register
    logic [spt_pkg::STATUS_W-1:0] res_status_reg;
    spt_pkg::rec_t                res_rec_reg;
    logic                         res_last_reg;

    // Equal ages list the later arrival first: invert the slot index in the key
    assign key_cur  = {rd_data_reg.age, ~pidx_reg};
    assign take_sev = pvld_reg && (mode_reg == spt_pkg::MODE_MAX_SEV)
                      && (rd_data_reg.sev > best_sev_reg);
    assign take_key = pvld_reg && (mode_reg == spt_pkg::MODE_MIN_KEY)
                      && (!have_prev_reg || (key_cur > prev_key_reg))
                      && (!found_reg || (key_cur < best_key_reg));

    assign idx_start = (cmd.sweep_mode == spt_pkg::MODE_SHIFT)
                       ? ({1'b0, best_idx_reg} + spt_pkg::CNT_W'(1))
                       : '0;

    // Pick the write source: appended record or shifted-down neighbour
    always_comb
    begin
        wr_en   = cmd.ins_write || (pvld_reg && (mode_reg == spt_pkg::MODE_SHIFT));
        wr_addr = cmd.ins_write ? fill_reg[spt_pkg::IDX_W-1:0]
                                : (pidx_reg - spt_pkg::IDX_W'(1));
        wr_data = cmd.ins_write ? in_rec_reg : rd_data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[idx_reg[spt_pkg::IDX_W-1:0]];
    end

    // Hold the input beat
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg       <= s_tuser;
            in_rec_reg.tag <= s_tdata[spt_pkg::TAG_W-1:0];
            in_rec_reg.age <= s_tdata[spt_pkg::TAG_W +: spt_pkg::AGE_W];
            in_rec_reg.sev <= s_tdata[spt_pkg::TAG_W + spt_pkg::AGE_W +: spt_pkg::SEV_W];
        end
    end

    // Fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (cmd.ins_write)
            fill_reg <= fill_reg + spt_pkg::CNT_W'(1);
        else if (cmd.fill_dec)
            fill_reg <= fill_reg - spt_pkg::CNT_W'(1);
    end

    // Walk slots from the start index up to the fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pvld_reg   <= 1'b0;
            idx_reg    <= '0;
            pidx_reg   <= '0;
            mode_reg   <= spt_pkg::MODE_MAX_SEV;
        end
        else
        begin
            pvld_reg <= active_reg && (idx_reg != fill_reg);
            pidx_reg <= idx_reg[spt_pkg::IDX_W-1:0];
            if (cmd.sweep_start)
            begin
                active_reg <= 1'b1;
                idx_reg    <= idx_start;
                mode_reg   <= cmd.sweep_mode;
            end
            else if (active_reg)
            begin
                if (idx_reg == fill_reg)
                    active_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + spt_pkg::CNT_W'(1);
            end
        end
    end

    // Track the best candidate of the current sweep and the list position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_sev_reg  <= '0;
            found_reg     <= 1'b0;
            have_prev_reg <= 1'b0;
            list_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.sweep_start)
            begin
                best_sev_reg <= '0;
                found_reg    <= 1'b0;
            end
            else
            begin
                if (take_sev)
                    best_sev_reg <= rd_data_reg.sev;
                if (take_key)
                    found_reg <= 1'b1;
            end
            if (cmd.list_reset)
            begin
                have_prev_reg <= 1'b0;
                list_cnt_reg  <= '0;
            end
            else if (cmd.list_next)
            begin
                have_prev_reg <= 1'b1;
                list_cnt_reg  <= list_cnt_reg + spt_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_sev)
        begin
            best_idx_reg <= pidx_reg;
            best_rec_reg <= rd_data_reg;
        end
        if (take_key)
        begin
            best_key_reg <= key_cur;
            best_rec_reg <= rd_data_reg;
        end
        if (cmd.list_next)
            prev_key_reg <= best_key_reg;
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_rec_reg    <= cmd.res_rec ? best_rec_reg : '0;
            res_last_reg   <= cmd.res_last;
        end
    end

    assign m_tdata = {{spt_pkg::OUT_PAD_W{1'b0}}, res_rec_reg.sev, res_rec_reg.age,
                      res_rec_reg.tag, res_status_reg};
    assign m_tlast = res_last_reg;

    // Status towards the controller
    always_comb
    begin
        sts.kind       = kind_reg;
        sts.sev_bad    = (in_rec_reg.sev < spt_pkg::SEV_MIN)
                         || (in_rec_reg.sev > spt_pkg::SEV_MAX);
        sts.full       = (fill_reg == spt_pkg::FILL_MAX);
        sts.empty      = (fill_reg == '0);
        sts.sweep_done = !active_reg && !pvld_reg;
        sts.list_last  = ((list_cnt_reg + spt_pkg::CNT_W'(1)) == fill_reg);
        sts.fill       = fill_reg;
    end

endmodule

FILE: rtl/severity_priority_table_core.sv
// Top level of the severity priority table: stream ports, controller and datapath.
//
// A table of up to 16 records (tag, age, severity 1 to 4) kept in arrival
// order. One input beat is taken at a time; s_tready is low until every result
// beat of the previous command has been taken. Insert appends a record and
// answers with one beat (ok, full, or bad severity, severity checked first).
// Remove picks the earliest arrival among the records of highest severity and
// returns it, or answers empty; it reads one slot per cycle for the search and
// one per cycle to close the gap. List returns every record in ascending age,
// later arrivals first among equal ages, with tlast on the final beat; each beat
// costs one full pass over the store. Every pass reads through the single read
// port of the record store. An empty table answers remove and list with one
// empty beat; command kind 3 is dropped without a result. No clearing pass is
// needed after reset.
module severity_priority_table_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata from bit 0: record_tag[15:0], age[7:0], severity[2:0], zero pad
    input  logic [spt_pkg::IN_DATA_W-1:0]     s_tdata,
    // s_tuser: kind[1:0]
    input  logic [spt_pkg::KIND_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata from bit 0: status[1:0], out_tag[15:0], out_age[7:0],
    // out_severity[2:0], zero pad
    output logic [spt_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tlast
);

    spt_pkg::cmd_t cmd;
    spt_pkg::sts_t sts;

    spt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    spt_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cmd     (cmd),
        .sts     (sts),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // Never take a new beat while a result is still offered
    assert property (@(posedge clk) disable iff (!rst_n) !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    // Fill count stays within the table
    assert property (@(posedge clk) disable iff (!rst_n) sts.fill <= spt_pkg::FILL_MAX)
        else $error("fill count beyond capacity");

    // Fill count moves by one record at most
    assert property (@(posedge clk) disable iff (!rst_n)
        (sts.fill != $past(sts.fill)) |->
        ((sts.fill == $past(sts.fill) + 1'b1) || (sts.fill + 1'b1 == $past(sts.fill))))
        else $error("fill count jumped");

    // An empty answer carries no record and ends the command
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] == spt_pkg::ST_EMPTY)) |->
        ((m_tdata[spt_pkg::OUT_BITS-1:spt_pkg::STATUS_W] == '0) && m_tlast))
        else $error("empty answer with record data");

endmodule
